// File: design/pcg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PCG32 generator package
// Widths, constants, codes, command and status types shared by the block.
// ----------------------------------------------------------------------------
package pcg_pkg;

   localparam int unsigned StateWidth   = 64;
   localparam int unsigned StreamWidth  = 63;
   localparam int unsigned HalfWidth    = 32;
   localparam int unsigned WordWidth    = 32;
   localparam int unsigned ValueWidth   = 53;
   localparam int unsigned CmdWidth     = 2;
   localparam int unsigned CsrAddrWidth = 2;
   localparam int unsigned CsrDataWidth = 64;
   localparam int unsigned BoundWidth   = 32;

   localparam int unsigned XshShift  = 18;
   localparam int unsigned XshDrop   = 27;
   localparam int unsigned RotShift  = 59;
   localparam int unsigned RotWidth  = StateWidth - RotShift;
   localparam int unsigned HiDrop    = 5;
   localparam int unsigned LoDrop    = 6;
   localparam int unsigned HiWidth   = WordWidth - HiDrop;
   localparam int unsigned LoWidth   = WordWidth - LoDrop;

   localparam int unsigned MaxDraws     = 64;
   localparam int unsigned DrawCntWidth = $clog2(MaxDraws + 1);
   localparam int unsigned DivCntWidth  = $clog2(WordWidth);

   localparam logic [StateWidth-1:0] DefaultMult = 64'd6364136223846793005;
   // state after a reseed with zero seed, zero stream and the default multiplier
   localparam logic [StateWidth-1:0] ResetState  = 64'd6364136223846793006;
   localparam logic [StateWidth-1:0] ResetInc    = 64'd1;

   typedef enum logic [CmdWidth-1:0] {
      CMD_RESEED   = 2'd0,
      CMD_RAW      = 2'd1,
      CMD_BOUNDED  = 2'd2,
      CMD_FRACTION = 2'd3
   } cmd_type;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_SEED   = 2'd0,
      CSR_STREAM = 2'd1,
      CSR_MULT   = 2'd2
   } csr_addr_type;

   typedef enum logic [2:0] {
      MUL_NONE = 3'd0,
      MUL_LL   = 3'd1,
      MUL_LH   = 3'd2,
      MUL_HL   = 3'd3,
      MUL_SUM  = 3'd4
   } mul_op_type;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'd0,
      ST_DECODE   = 4'd1,
      ST_MUL0     = 4'd2,
      ST_MUL1     = 4'd3,
      ST_MUL2     = 4'd4,
      ST_MUL3     = 4'd5,
      ST_ADVANCE  = 4'd6,
      ST_ADD_SEED = 4'd7,
      ST_CHECK    = 4'd8,
      ST_DIV_RUN  = 4'd9,
      ST_RESULT   = 4'd10
   } ctrl_state_type;

   typedef struct packed {
      logic       load_item;
      logic       reseed_init;
      mul_op_type mul_op;
      logic       advance;
      logic       save_hi;
      logic       add_seed;
      logic       div_start_thr;
      logic       div_start_word;
      logic       save_thr;
      logic       load_result;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type command;
      logic    bound_zero;
      logic    word_ok;
      logic    div_done;
   } dp_status_type;

   // XSH-RR output function of the state before the advance
   function automatic logic [WordWidth-1:0] output_word(input logic [StateWidth-1:0] s);
      logic [StateWidth-1:0]  mix;
      logic [WordWidth-1:0]   x;
      logic [RotWidth-1:0]    r;
      logic [2*WordWidth-1:0] dbl;
      mix = (s >> XshShift) ^ s;
      x   = mix[XshDrop +: WordWidth];
      r   = s[RotShift +: RotWidth];
      dbl = {x, x} >> r;
      return dbl[WordWidth-1:0];
   endfunction

endpackage
`default_nettype wire

// File: design/pcg_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PCG32 channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcg_req_if;
   logic                            valid;
   logic                            ready;
   logic [pcg_pkg::CmdWidth-1:0]    command;
   logic [pcg_pkg::BoundWidth-1:0]  bound;
   modport source (output valid, output command, output bound, input ready);
   modport sink   (input valid, input command, input bound, output ready);
endinterface

interface pcg_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pcg_pkg::ValueWidth-1:0]   value;
   logic                             error;
   logic [pcg_pkg::StateWidth-1:0]   current_state;
   logic [pcg_pkg::StreamWidth-1:0]  current_stream;
   modport source (output valid, output value, output error, output current_state,
                   output current_stream, input ready);
   modport sink   (input valid, input value, input error, input current_state,
                   input current_stream, output ready);
endinterface

interface pcg_csr_if;
   logic                              valid;
   logic                              ready;
   logic [pcg_pkg::CsrAddrWidth-1:0]  addr;
   logic [pcg_pkg::CsrDataWidth-1:0]  data;
   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

// File: design/pcg32_random_generator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PCG32 random generator (XSH-RR, 64-bit state, 32-bit output)
// Reseed, raw word, bounded value by rejection and 53-bit unit fraction commands.
//
//   channel   dir   beat
//   req_bus   in    command, bound
//   rsp_bus   out   value, error, current_state, current_stream
//   csr_bus   in    addr (0 seed, 1 stream, 2 multiplier), data
//
// A state advance forms three partial products on the shared 32x32 multiplier,
// sums them and then adds the increment. A reseed advances twice, a fraction
// draws two words, a zero bound returns an error without a draw; any other bounded
// value runs two remainder passes and draws until a word passes or 64 are drawn.
// One item is worked at a time; the next beat is taken while a finished
// response waits in the output register. Register writes are always ready.
// ----------------------------------------------------------------------------
module pcg32_random_generator_top (
   input wire logic  clock,
   input wire logic  reset,
   pcg_req_if.sink   req_bus,
   pcg_rsp_if.source rsp_bus,
   pcg_csr_if.sink   csr_bus
);

   pcg_pkg::dp_cmd_type    dp_cmd;
   pcg_pkg::dp_status_type dp_status;
   logic                   csr_write;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid & csr_bus.ready;

   pcg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (dp_cmd),
      .status    (dp_status)
   );

   pcg_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .status      (dp_status),
      .csr_write   (csr_write),
      .csr_addr    (csr_bus.addr),
      .csr_data    (csr_bus.data),
      .req_command (req_bus.command),
      .req_bound   (req_bus.bound),
      .rsp_value   (rsp_bus.value),
      .rsp_error   (rsp_bus.error),
      .rsp_state   (rsp_bus.current_state),
      .rsp_stream  (rsp_bus.current_stream)
   );

endmodule
`default_nettype wire

// File: design/pcg_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PCG32 remainder unit
// Restoring divider, one quotient bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module pcg_divider (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [pcg_pkg::WordWidth-1:0]    dividend,
   input  wire logic [pcg_pkg::WordWidth-1:0]    divisor,
   output      logic [pcg_pkg::WordWidth-1:0]    remainder,
   output      logic                             done
);

   logic [pcg_pkg::WordWidth-1:0]   rem_ff, rem_in;
   logic [pcg_pkg::WordWidth-1:0]   dvd_ff, dvd_in;
   logic [pcg_pkg::DivCntWidth-1:0] cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [pcg_pkg::WordWidth:0]     trial;
   logic [pcg_pkg::WordWidth:0]     diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[pcg_pkg::WordWidth-1]};
      diff    = trial - {1'b0, divisor};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = diff[pcg_pkg::WordWidth] ? trial[pcg_pkg::WordWidth-1:0]
                                           : diff[pcg_pkg::WordWidth-1:0];
         dvd_in = {dvd_ff[pcg_pkg::WordWidth-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == pcg_pkg::DivCntWidth'(pcg_pkg::WordWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule
`default_nettype wire

// File: design/pcg_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PCG32 datapath
// Registers, state and increment, shared 32x32 multiplier, remainder unit
// and the response register.
// ----------------------------------------------------------------------------
module pcg_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pcg_pkg::dp_cmd_type                 cmd,
   output      pcg_pkg::dp_status_type              status,
   input  wire logic                                csr_write,
   input  wire logic [pcg_pkg::CsrAddrWidth-1:0]    csr_addr,
   input  wire logic [pcg_pkg::CsrDataWidth-1:0]    csr_data,
   input  wire logic [pcg_pkg::CmdWidth-1:0]        req_command,
   input  wire logic [pcg_pkg::BoundWidth-1:0]      req_bound,
   output      logic [pcg_pkg::ValueWidth-1:0]      rsp_value,
   output      logic                                rsp_error,
   output      logic [pcg_pkg::StateWidth-1:0]      rsp_state,
   output      logic [pcg_pkg::StreamWidth-1:0]     rsp_stream
);

   logic [pcg_pkg::StateWidth-1:0]   seed_ff;
   logic [pcg_pkg::StreamWidth-1:0]  stream_ff;
   logic [pcg_pkg::StateWidth-1:0]   mult_ff;
   logic [pcg_pkg::StateWidth-1:0]   state_ff, state_in;
   logic [pcg_pkg::StateWidth-1:0]   inc_ff, inc_in;
   pcg_pkg::cmd_type                 command_ff;
   logic [pcg_pkg::BoundWidth-1:0]   bound_ff;
   logic [pcg_pkg::StateWidth-1:0]   prod_ff;
   logic [pcg_pkg::StateWidth-1:0]   lo_ff;
   logic [pcg_pkg::HalfWidth-1:0]    mid_ff;
   logic [pcg_pkg::WordWidth-1:0]    word_ff;
   logic [pcg_pkg::HiWidth-1:0]      hi_ff;
   logic [pcg_pkg::WordWidth-1:0]    thr_ff;
   logic [pcg_pkg::ValueWidth-1:0]   value_ff, value_in;
   logic                             error_ff;
   logic [pcg_pkg::StateWidth-1:0]   out_state_ff;
   logic [pcg_pkg::StreamWidth-1:0]  out_stream_ff;

   logic [pcg_pkg::HalfWidth-1:0]    mul_a, mul_b;
   logic                             mul_load;
   logic [pcg_pkg::HalfWidth-1:0]    mid_sum;
   logic [pcg_pkg::WordWidth-1:0]    cur_word;
   logic                             div_start;
   logic [pcg_pkg::WordWidth-1:0]    div_dividend;
   logic [pcg_pkg::WordWidth-1:0]    div_rem;
   logic                             div_done;
   logic                             bound_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= '0;
         stream_ff <= '0;
         mult_ff   <= pcg_pkg::DefaultMult;
      end else if (csr_write) begin
         case (pcg_pkg::csr_addr_type'(csr_addr))
            pcg_pkg::CSR_SEED:   seed_ff   <= csr_data;
            pcg_pkg::CSR_STREAM: stream_ff <= csr_data[pcg_pkg::StreamWidth-1:0];
            pcg_pkg::CSR_MULT:   mult_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         command_ff <= pcg_pkg::cmd_type'(req_command);
         bound_ff   <= req_bound;
      end
   end

   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      mul_load = 1'b0;
      case (cmd.mul_op)
         pcg_pkg::MUL_LL: begin
            mul_a    = state_ff[pcg_pkg::HalfWidth-1:0];
            mul_b    = mult_ff[pcg_pkg::HalfWidth-1:0];
            mul_load = 1'b1;
         end
         pcg_pkg::MUL_LH: begin
            mul_a    = state_ff[pcg_pkg::HalfWidth-1:0];
            mul_b    = mult_ff[pcg_pkg::StateWidth-1:pcg_pkg::HalfWidth];
            mul_load = 1'b1;
         end
         pcg_pkg::MUL_HL: begin
            mul_a    = state_ff[pcg_pkg::StateWidth-1:pcg_pkg::HalfWidth];
            mul_b    = mult_ff[pcg_pkg::HalfWidth-1:0];
            mul_load = 1'b1;
         end
         default: ;
      endcase
   end

   assign mid_sum  = mid_ff + prod_ff[pcg_pkg::HalfWidth-1:0];
   assign cur_word = pcg_pkg::output_word(state_ff);

   always_ff @(posedge clock) begin
      if (mul_load) begin
         prod_ff <= pcg_pkg::StateWidth'(mul_a) * pcg_pkg::StateWidth'(mul_b);
      end
      case (cmd.mul_op)
         pcg_pkg::MUL_LH:  lo_ff  <= prod_ff;
         pcg_pkg::MUL_HL:  mid_ff <= prod_ff[pcg_pkg::HalfWidth-1:0];
         pcg_pkg::MUL_SUM: lo_ff  <= lo_ff + {mid_sum, {pcg_pkg::HalfWidth{1'b0}}};
         default: ;
      endcase
      if (cmd.advance) begin
         word_ff <= cur_word;
      end
      if (cmd.save_hi) begin
         hi_ff <= cur_word[pcg_pkg::WordWidth-1:pcg_pkg::HiDrop];
      end
      if (cmd.save_thr) begin
         thr_ff <= div_rem;
      end
   end

   always_comb begin
      state_in = state_ff;
      inc_in   = inc_ff;
      if (cmd.reseed_init) begin
         state_in = '0;
         inc_in   = {stream_ff, 1'b1};
      end else if (cmd.advance) begin
         state_in = lo_ff + inc_ff;
      end else if (cmd.add_seed) begin
         state_in = state_ff + seed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcg_pkg::ResetState;
         inc_ff   <= pcg_pkg::ResetInc;
      end else begin
         state_ff <= state_in;
         inc_ff   <= inc_in;
      end
   end

   assign bound_zero   = (bound_ff == '0);
   assign div_start    = cmd.div_start_thr | cmd.div_start_word;
   assign div_dividend = cmd.div_start_thr ? (~bound_ff + 1'b1) : word_ff;

   pcg_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (bound_ff),
      .remainder (div_rem),
      .done      (div_done)
   );

   always_comb begin
      value_in = '0;
      case (command_ff)
         pcg_pkg::CMD_RESEED:   value_in = '0;
         pcg_pkg::CMD_RAW:      value_in = pcg_pkg::ValueWidth'(word_ff);
         pcg_pkg::CMD_BOUNDED:  value_in = bound_zero ? '0 : pcg_pkg::ValueWidth'(div_rem);
         pcg_pkg::CMD_FRACTION: value_in = {hi_ff, word_ff[pcg_pkg::WordWidth-1:pcg_pkg::LoDrop]};
         default:               value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         value_ff      <= value_in;
         error_ff      <= (command_ff == pcg_pkg::CMD_BOUNDED) && bound_zero;
         out_state_ff  <= state_ff;
         out_stream_ff <= inc_ff[pcg_pkg::StateWidth-1:1];
      end
   end

   assign status.command    = command_ff;
   assign status.bound_zero = bound_zero;
   assign status.word_ok    = (word_ff >= thr_ff);
   assign status.div_done   = div_done;

   assign rsp_value  = value_ff;
   assign rsp_error  = error_ff;
   assign rsp_state  = out_state_ff;
   assign rsp_stream = out_stream_ff;

endmodule
`default_nettype wire

// File: design/pcg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PCG32 controller
// Sequences reseed, draws, rejection loop and remainders; owns the request and response handshakes.
// ----------------------------------------------------------------------------
module pcg_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      pcg_pkg::dp_cmd_type      cmd,
   input  wire pcg_pkg::dp_status_type   status
);

   pcg_pkg::ctrl_state_type             state_ff, state_in;
   logic [pcg_pkg::DrawCntWidth-1:0]    draw_cnt_ff, draw_cnt_in;
   logic                                thr_phase_ff, thr_phase_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                first_draw;

   assign first_draw = (draw_cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcg_pkg::ST_IDLE;
         draw_cnt_ff  <= '0;
         thr_phase_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         draw_cnt_ff  <= draw_cnt_in;
         thr_phase_ff <= thr_phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      draw_cnt_in  = draw_cnt_ff;
      thr_phase_in = thr_phase_ff;
      cmd          = '0;
      cmd.mul_op   = pcg_pkg::MUL_NONE;
      req_ready    = 1'b0;
      case (state_ff)
         pcg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               draw_cnt_in   = '0;
               state_in      = pcg_pkg::ST_DECODE;
            end
         end
         pcg_pkg::ST_DECODE: begin
            case (status.command)
               pcg_pkg::CMD_RESEED: begin
                  cmd.reseed_init = 1'b1;
                  state_in        = pcg_pkg::ST_MUL0;
               end
               pcg_pkg::CMD_BOUNDED: begin
                  if (status.bound_zero) begin
                     state_in = pcg_pkg::ST_RESULT;
                  end else begin
                     cmd.div_start_thr = 1'b1;
                     thr_phase_in      = 1'b1;
                     state_in          = pcg_pkg::ST_DIV_RUN;
                  end
               end
               default: state_in = pcg_pkg::ST_MUL0;
            endcase
         end
         pcg_pkg::ST_MUL0: begin
            cmd.mul_op = pcg_pkg::MUL_LL;
            state_in   = pcg_pkg::ST_MUL1;
         end
         pcg_pkg::ST_MUL1: begin
            cmd.mul_op = pcg_pkg::MUL_LH;
            state_in   = pcg_pkg::ST_MUL2;
         end
         pcg_pkg::ST_MUL2: begin
            cmd.mul_op = pcg_pkg::MUL_HL;
            state_in   = pcg_pkg::ST_MUL3;
         end
         pcg_pkg::ST_MUL3: begin
            cmd.mul_op = pcg_pkg::MUL_SUM;
            state_in   = pcg_pkg::ST_ADVANCE;
         end
         pcg_pkg::ST_ADVANCE: begin
            cmd.advance = 1'b1;
            draw_cnt_in = draw_cnt_ff + 1'b1;
            case (status.command)
               pcg_pkg::CMD_RESEED:
                  state_in = first_draw ? pcg_pkg::ST_ADD_SEED : pcg_pkg::ST_RESULT;
               pcg_pkg::CMD_BOUNDED:
                  state_in = pcg_pkg::ST_CHECK;
               pcg_pkg::CMD_FRACTION: begin
                  cmd.save_hi = first_draw;
                  state_in    = first_draw ? pcg_pkg::ST_MUL0 : pcg_pkg::ST_RESULT;
               end
               default: state_in = pcg_pkg::ST_RESULT;
            endcase
         end
         pcg_pkg::ST_ADD_SEED: begin
            cmd.add_seed = 1'b1;
            state_in     = pcg_pkg::ST_MUL0;
         end
         pcg_pkg::ST_CHECK: begin
            if (status.word_ok ||
                draw_cnt_ff == pcg_pkg::DrawCntWidth'(pcg_pkg::MaxDraws)) begin
               cmd.div_start_word = 1'b1;
               thr_phase_in       = 1'b0;
               state_in           = pcg_pkg::ST_DIV_RUN;
            end else begin
               state_in = pcg_pkg::ST_MUL0;
            end
         end
         pcg_pkg::ST_DIV_RUN: begin
            if (status.div_done) begin
               if (thr_phase_ff) begin
                  cmd.save_thr = 1'b1;
                  state_in     = pcg_pkg::ST_MUL0;
               end else begin
                  state_in = pcg_pkg::ST_RESULT;
               end
            end
         end
         pcg_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_result = 1'b1;
               state_in        = pcg_pkg::ST_IDLE;
            end
         end
         default: state_in = pcg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire
